// ----- design/sceq_pkg.sv -----
`timescale 1ns / 1ps
// package for the status change event queue: widths, event codes, commands,
// register indexes, shared structs and ring pointer helpers
// no dependencies
package sceq_pkg;

    localparam int RING_SLOTS = 16;
    localparam int PTR_W      = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;

    localparam int CODE_W     = 4;
    localparam int NUM_CODES  = 8;
    localparam int CMD_W      = 2;
    localparam int LOCK_W     = 8;
    localparam int REF_W      = 8;
    localparam int ALARM_W    = 64;
    localparam int FILL_W     = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 16;

    // commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd2;

    // event codes, also bit positions in the pending vector
    localparam int CODE_LOCK_ACQUIRED = 0;
    localparam int CODE_LOCK_LOST     = 1;
    localparam int CODE_HOLD_ENTER    = 2;
    localparam int CODE_HOLD_EXIT     = 3;
    localparam int CODE_REF_SWITCH    = 4;
    localparam int CODE_THERMAL       = 5;
    localparam int CODE_ANTENNA       = 6;
    localparam int CODE_RAIL          = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCKED_STATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THERMAL_MASK = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANTENNA_MASK = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAIL_MASK    = 8'd3;

    localparam logic [LOCK_W-1:0] LOCKED_STATE_RESET = 8'd2;

    typedef struct packed {
        logic [LOCK_W-1:0]  lock_status;
        logic [REF_W-1:0]   active_reference;
        logic               in_holdover;
        logic [ALARM_W-1:0] alarm_word;
    } t_sample;

    typedef struct packed {
        logic [LOCK_W-1:0]  locked_state_value;
        logic [ALARM_W-1:0] thermal_alarm_mask;
        logic [ALARM_W-1:0] antenna_alarm_mask;
        logic [ALARM_W-1:0] rail_alarm_mask;
    } t_cfg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(RING_SLOTS - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

    // lowest set bit of the pending vector, which is also the code to push
    function automatic logic [CODE_W-1:0] first_code(input logic [NUM_CODES-1:0] pend);
        logic [CODE_W-1:0] res;
        res = '0;
        for (int i = NUM_CODES - 1; i >= 0; i--) begin
            if (pend[i]) begin
                res = CODE_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// ----- design/status_change_event_queue.sv -----
`timescale 1ns / 1ps
// status change event queue top: config registers, push/pop sequencer, ring
// pointers and output register; depends on sceq_pkg, sceq_detect, sceq_ring_ram
//
// channel   direction  fields (lowest bit first)
// s_axis    in         tuser: command; tdata: lock_status, active_reference,
//                      in_holdover, alarm_word, event_code
// m_axis    out        tuser: event_valid; tdata: event_out, fill_level, overflow
// cfg       in         i_cfg_index: register index; i_cfg_data: value
//
// one request at a time: a sample pushes each raised code in turn, an enqueue
// pushes its one code, and a dequeue waits for the registered ring read.
// the ring write port moves one code per cycle and bounds the sample time.
// reset is synchronous, active low; the ring contents need no clearing.
// a waiting result blocks only the finish of the next request, not its accept.
module status_change_event_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // lock_status[7:0], active_reference[15:8], in_holdover[16],
    // alarm_word[80:17], event_code[84:81], zero pad[87:85]
    input  logic [sceq_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  logic [sceq_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // event_out[3:0], fill_level[7:4], overflow[8], zero pad[15:9]
    output logic [sceq_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // event_valid[0]
    output logic                              m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sceq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sceq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                       r_state;
    sceq_pkg::t_cfg                   r_cfg;
    logic [sceq_pkg::PTR_W-1:0]       r_wp;
    logic [sceq_pkg::PTR_W-1:0]       r_rp;
    logic [sceq_pkg::NUM_CODES-1:0]   r_pend;
    logic                             r_ext;
    logic [sceq_pkg::CODE_W-1:0]      r_ext_code;
    logic                             r_drop;
    logic                             r_evalid;
    logic [sceq_pkg::CODE_W-1:0]      r_code;
    logic                             r_m_valid;
    logic                             r_m_evalid;
    logic [sceq_pkg::CODE_W-1:0]      r_m_code;
    logic [sceq_pkg::FILL_W-1:0]      r_m_fill;
    logic                             r_m_ovf;

    logic                             in_acc;
    logic [sceq_pkg::CMD_W-1:0]       cmd;
    sceq_pkg::t_sample                sample;
    logic [sceq_pkg::CODE_W-1:0]      in_code;
    logic [sceq_pkg::NUM_CODES-1:0]   det_pend;
    logic [sceq_pkg::NUM_CODES-1:0]   n_pend;
    logic [sceq_pkg::CODE_W-1:0]      push_code;
    logic [sceq_pkg::PTR_W-1:0]       n_wp;
    logic                             full;
    logic                             push_we;
    logic                             push_last;
    logic                             rd_en;
    logic [sceq_pkg::CODE_W-1:0]      rd_data;
    logic [sceq_pkg::PTR_W:0]         fill_w;
    logic                             out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cmd           = s_axis_tuser;

    assign sample.lock_status      = s_axis_tdata[7:0];
    assign sample.active_reference = s_axis_tdata[15:8];
    assign sample.in_holdover      = s_axis_tdata[16];
    assign sample.alarm_word       = s_axis_tdata[80:17];
    assign in_code                 = s_axis_tdata[84:81];

    sceq_detect u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_we (in_acc && (cmd == sceq_pkg::CMD_SAMPLE)),
        .i_sample    (sample),
        .i_cfg       (r_cfg),
        .o_pend      (det_pend)
    );

    // push sequencer: detected codes first in code order, else the enqueued one
    always_comb begin
        n_pend    = r_pend & (r_pend - sceq_pkg::NUM_CODES'(1));
        push_code = (r_pend != '0) ? sceq_pkg::first_code(r_pend) : r_ext_code;
        n_wp      = sceq_pkg::ptr_inc(r_wp);
        full      = (n_wp == r_rp);
        push_we   = (r_state == ST_PUSH) && !full;
        push_last = (r_pend != '0) ? ((n_pend == '0) && !r_ext) : 1'b1;
        rd_en     = in_acc && (cmd == sceq_pkg::CMD_DEQUEUE) && (r_rp != r_wp);
    end

    sceq_ring_ram u_ring (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (r_wp),
        .i_wdata (push_code),
        .i_re    (rd_en),
        .i_raddr (r_rp),
        .o_rdata (rd_data)
    );

    always_comb begin
        if (r_wp >= r_rp) begin
            fill_w = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            fill_w = {1'b0, r_wp} + (sceq_pkg::PTR_W + 1)'(sceq_pkg::RING_SLOTS)
                     - {1'b0, r_rp};
        end
    end

    assign out_free = !r_m_valid || m_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.locked_state_value <= sceq_pkg::LOCKED_STATE_RESET;
            r_cfg.thermal_alarm_mask <= '0;
            r_cfg.antenna_alarm_mask <= '0;
            r_cfg.rail_alarm_mask    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sceq_pkg::REG_LOCKED_STATE: begin
                    r_cfg.locked_state_value <= i_cfg_data[sceq_pkg::LOCK_W-1:0];
                end
                sceq_pkg::REG_THERMAL_MASK: r_cfg.thermal_alarm_mask <= i_cfg_data;
                sceq_pkg::REG_ANTENNA_MASK: r_cfg.antenna_alarm_mask <= i_cfg_data;
                sceq_pkg::REG_RAIL_MASK:    r_cfg.rail_alarm_mask    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request sequencer and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_pend   <= '0;
            r_ext    <= 1'b0;
            r_drop   <= 1'b0;
            r_evalid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_drop     <= 1'b0;
                        r_evalid   <= 1'b0;
                        r_code     <= '0;
                        r_ext_code <= in_code;
                        r_pend     <= '0;
                        r_ext      <= 1'b0;
                        case (cmd)
                            sceq_pkg::CMD_SAMPLE: begin
                                r_pend  <= det_pend;
                                r_state <= (det_pend != '0) ? ST_PUSH : ST_DONE;
                            end
                            sceq_pkg::CMD_ENQUEUE: begin
                                r_ext   <= 1'b1;
                                r_state <= ST_PUSH;
                            end
                            sceq_pkg::CMD_DEQUEUE: begin
                                r_state <= (r_rp != r_wp) ? ST_READ : ST_DONE;
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_PUSH: begin
                    if (full) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_wp <= n_wp;
                    end
                    if (r_pend != '0) begin
                        r_pend <= n_pend;
                    end else begin
                        r_ext <= 1'b0;
                    end
                    if (push_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_READ: begin
                    r_code   <= rd_data;
                    r_evalid <= 1'b1;
                    r_rp     <= sceq_pkg::ptr_inc(r_rp);
                    r_state  <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_m_evalid <= r_evalid;
            r_m_code   <= r_code;
            r_m_fill   <= sceq_pkg::FILL_W'(fill_w);
            r_m_ovf    <= r_drop;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_evalid;
    assign m_axis_tdata  = {7'd0, r_m_ovf, r_m_fill, r_m_code};

endmodule

// ----- design/sceq_ring_ram.sv -----
`timescale 1ns / 1ps
// event ring storage: one write port, one read port, registered read data
// depends on sceq_pkg for depth and code width
module sceq_ring_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [sceq_pkg::PTR_W-1:0]   i_waddr,
    input  logic [sceq_pkg::CODE_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [sceq_pkg::PTR_W-1:0]   i_raddr,
    output logic [sceq_pkg::CODE_W-1:0]  o_rdata
);

    logic [sceq_pkg::CODE_W-1:0] r_mem [sceq_pkg::RING_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- design/sceq_detect.sv -----
`timescale 1ns / 1ps
// change detector: keeps the previous sample and flags the event codes a new
// sample raises; depends on sceq_pkg for the sample and config structs
module sceq_detect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_sample_we,
    input  sceq_pkg::t_sample                 i_sample,
    input  sceq_pkg::t_cfg                    i_cfg,
    output logic [sceq_pkg::NUM_CODES-1:0]    o_pend
);

    logic                        r_primed;
    sceq_pkg::t_sample           r_last;
    logic                        now_locked;
    logic                        was_locked;
    logic [sceq_pkg::ALARM_W-1:0] rising;

    always_comb begin
        now_locked = (i_sample.lock_status == i_cfg.locked_state_value);
        was_locked = (r_last.lock_status == i_cfg.locked_state_value);
        rising     = i_sample.alarm_word & ~r_last.alarm_word;

        o_pend = '0;
        o_pend[sceq_pkg::CODE_LOCK_ACQUIRED] = now_locked && !was_locked;
        o_pend[sceq_pkg::CODE_LOCK_LOST]     = was_locked && !now_locked;
        o_pend[sceq_pkg::CODE_HOLD_ENTER]    = i_sample.in_holdover && !r_last.in_holdover;
        o_pend[sceq_pkg::CODE_HOLD_EXIT]     = !i_sample.in_holdover && r_last.in_holdover;
        o_pend[sceq_pkg::CODE_REF_SWITCH]    =
            (i_sample.active_reference != r_last.active_reference);
        o_pend[sceq_pkg::CODE_THERMAL]       = |(rising & i_cfg.thermal_alarm_mask);
        o_pend[sceq_pkg::CODE_ANTENNA]       = |(rising & i_cfg.antenna_alarm_mask);
        o_pend[sceq_pkg::CODE_RAIL]          = |(rising & i_cfg.rail_alarm_mask);
        // first sample only primes
        if (!r_primed) begin
            o_pend = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_last   <= '0;
        end else if (i_sample_we) begin
            r_primed <= 1'b1;
            r_last   <= i_sample;
        end
    end

endmodule
